/* design/mct_pkg.sv */
package mct_pkg;

   localparam int ELEM_W      = 32;
   localparam int N_ELEM      = 4;
   localparam int COL_W       = 2;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_TRANSFORM = 1'b1
   } opcode_type;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic                          is_load;
      logic [COL_W-1:0]              col;
      logic [N_ELEM-1:0][ELEM_W-1:0] elem;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* design/mct_front.sv */
module mct_front #(
   parameter int DIM = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [1:0]              req_column_index,
   input  mct_pkg::elem_type       req_elem_x,
   input  mct_pkg::elem_type       req_elem_y,
   input  mct_pkg::elem_type       req_elem_z,
   input  mct_pkg::elem_type       req_elem_w,
   output logic                    push,
   output mct_pkg::cmd_type        push_cmd,
   input  mct_pkg::qstat_type      qstat
);
   import mct_pkg::*;

   logic    front_valid_ff;
   cmd_type front_cmd_ff;
   cmd_type cmd_in;
   logic    accept;
   logic    keep;

   assign req_ready = !front_valid_ff || !qstat.full;
   assign accept    = req_valid && req_ready;
   assign push      = front_valid_ff && !qstat.full;
   assign push_cmd  = front_cmd_ff;

   // loads to a column outside the matrix are dropped here
   always_comb begin
      cmd_in.is_load = (req_opcode == OP_LOAD);
      cmd_in.col     = req_column_index;
      cmd_in.elem[0] = req_elem_x;
      cmd_in.elem[1] = req_elem_y;
      cmd_in.elem[2] = req_elem_z;
      cmd_in.elem[3] = req_elem_w;
      keep = (req_opcode == OP_TRANSFORM) || (int'(req_column_index) < DIM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (accept) begin
         front_valid_ff <= keep;
      end else if (push) begin
         front_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_cmd_ff <= cmd_in;
      end
   end

endmodule

/* design/mct_fifo.sv */
module mct_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mct_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output mct_pkg::cmd_type   pop_cmd,
   output mct_pkg::qstat_type qstat
);
   import mct_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_cmd     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* design/mct_back.sv */
module mct_back #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   output logic               pop,
   input  mct_pkg::cmd_type   pop_cmd,
   input  mct_pkg::qstat_type qstat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mct_pkg::elem_type  rsp_out_x,
   output mct_pkg::elem_type  rsp_out_y,
   output mct_pkg::elem_type  rsp_out_z,
   output mct_pkg::elem_type  rsp_out_w,
   output logic               rsp_saturated
);
   import mct_pkg::*;

   elem_type                  mat_ff  [N_ELEM][N_ELEM];
   logic signed [PROD_W-1:0]  prod_ff [N_ELEM][N_ELEM];
   logic signed [PROD_W-1:0]  prod_in [N_ELEM][N_ELEM];
   logic signed [SUM_W-1:0]   sum_ff  [N_ELEM];
   logic signed [SUM_W-1:0]   sum_in  [N_ELEM];
   elem_type                  out_ff  [N_ELEM];
   elem_type                  out_in  [N_ELEM];
   logic                      sat_ff;
   logic                      sat_in;
   logic                      s1_valid_ff;
   logic                      s2_valid_ff;
   logic                      rsp_valid_ff;
   logic                      advance;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && !qstat.empty;

   // mat_ff[column][row]; each product has its own multiplier
   always_comb begin
      for (int r = 0; r < N_ELEM; r++) begin
         for (int k = 0; k < N_ELEM; k++) begin
            if (r < DIM && k < DIM) begin
               prod_in[r][k] = mat_ff[k][r] * $signed(pop_cmd.elem[k]);
            end else begin
               prod_in[r][k] = '0;
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < N_ELEM; r++) begin
         sum_in[r] = '0;
         for (int k = 0; k < N_ELEM; k++) begin
            sum_in[r] = sum_in[r] + SUM_W'(prod_ff[r][k]);
         end
      end
   end

   // floor shift, then clip to 32 bits
   always_comb begin
      logic signed [SUM_W-1:0] shifted;
      logic                    fits;
      sat_in  = 1'b0;
      shifted = '0;
      fits    = 1'b1;
      for (int r = 0; r < N_ELEM; r++) begin
         shifted = sum_ff[r] >>> FRAC_BITS;
         fits    = (&shifted[SUM_W-1:ELEM_W-1]) || !(|shifted[SUM_W-1:ELEM_W-1]);
         if (fits) begin
            out_in[r] = shifted[ELEM_W-1:0];
         end else if (sum_ff[r][SUM_W-1]) begin
            out_in[r] = ELEM_MIN;
         end else begin
            out_in[r] = ELEM_MAX;
         end
         sat_in = sat_in || !fits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < N_ELEM; c++) begin
            for (int r = 0; r < N_ELEM; r++) begin
               mat_ff[c][r] <= (c == r && r < DIM) ? (ELEM_W'(1) << FRAC_BITS) : '0;
            end
         end
      end else begin
         if (advance) begin
            s1_valid_ff  <= pop && !pop_cmd.is_load;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
         if (pop && pop_cmd.is_load) begin
            for (int r = 0; r < N_ELEM; r++) begin
               if (r < DIM) begin
                  mat_ff[pop_cmd.col][r] <= pop_cmd.elem[r];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_out_w     = out_ff[3];
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   a_load_written: assert property (@(posedge clock) disable iff (reset)
      pop && pop_cmd.is_load |=>
         mat_ff[$past(pop_cmd.col)][0] == $past(pop_cmd.elem[0]))
      else $error("column load not stored");
   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("beat without pipeline source");
   a_unused_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (DIM == N_ELEM) || (out_ff[N_ELEM-1] == '0))
      else $error("row outside matrix not zero");
`endif

endmodule

/* design/mat4_column_transform.sv */
// 4x4 column-major Q16.16 matrix times vector. A load beat (opcode 0) writes one matrix
// column and gives no response; a transform beat (opcode 1) gives one response beat with
// the four row dot products, each floored by FRAC_BITS and clipped to 32 bits, and a
// saturated flag. The block takes one beat per clock while req_ready is high: the sixteen 32x32
// multipliers work in parallel, and a four-entry queue separates the input stage from the compute
// pipeline. A transform beat passes the input register, the queue and the product, sum and output
// registers; loads take effect in order with transforms. The matrix resets to identity. With DIM 3,
// the fourth row and column are zero, elem_w of a transform is ignored and out_w is 0.
module mat4_column_transform #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [1:0]        req_column_index,
   input  mct_pkg::elem_type req_elem_x,
   input  mct_pkg::elem_type req_elem_y,
   input  mct_pkg::elem_type req_elem_z,
   input  mct_pkg::elem_type req_elem_w,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mct_pkg::elem_type rsp_out_x,
   output mct_pkg::elem_type rsp_out_y,
   output mct_pkg::elem_type rsp_out_z,
   output mct_pkg::elem_type rsp_out_w,
   output logic              rsp_saturated
);
   import mct_pkg::*;

   logic      push;
   cmd_type   push_cmd;
   logic      pop;
   cmd_type   pop_cmd;
   qstat_type qstat;

   mct_front #(
      .DIM (DIM)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_column_index (req_column_index),
      .req_elem_x       (req_elem_x),
      .req_elem_y       (req_elem_y),
      .req_elem_z       (req_elem_z),
      .req_elem_w       (req_elem_w),
      .push             (push),
      .push_cmd         (push_cmd),
      .qstat            (qstat)
   );

   mct_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   mct_back #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop           (pop),
      .pop_cmd       (pop_cmd),
      .qstat         (qstat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w),
      .rsp_saturated (rsp_saturated)
   );

endmodule
